FILE: hw/rtl/min_max_stack_unit_assert.svh
// Assertion macros used by the RTL of the min/max stack unit.
`ifndef MIN_MAX_STACK_UNIT_ASSERT_SVH
`define MIN_MAX_STACK_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is high.
`define MMS_ASSERT_IMPLY(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define MMS_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error(msg);

`else

`define MMS_ASSERT_IMPLY(label, clk, rst, lhs, rhs, msg)
`define MMS_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg)

`endif

`endif

FILE: hw/rtl/mms_pkg.sv
// Types and constants of the min/max stack unit.
`timescale 1ns / 1ps

package mms_pkg;

   localparam int DEFAULT_STACK_DEPTH = 64;
   localparam int DATA_W              = 32;
   localparam int FILL_W              = 7;

   // Operation codes
   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   // Status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

   typedef struct packed {
      logic                     cmd;
      logic signed [DATA_W-1:0] value;
   } mms_req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] top_value;
      logic signed [DATA_W-1:0] min_value;
      logic signed [DATA_W-1:0] max_value;
      logic [FILL_W-1:0]        fill_count;
      logic                     is_full;
      logic                     is_empty;
      logic [1:0]               status;
   } mms_rsp_type;

   // One stack entry: value and running min/max of it and all entries below
   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] run_min;
      logic signed [DATA_W-1:0] run_max;
   } mms_entry_type;

endpackage

FILE: hw/rtl/mms_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module mms_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/min_max_stack_unit.sv
// Top level of the min/max stack unit: a bounded stack that tracks min and max.
`timescale 1ns / 1ps
// Usage
//   req channel: one word per operation, cmd (push/pop) and value. A word is
//     taken at a clock edge with req_valid high and req_stall low.
//   rsp channel: one word per operation: top value (popped value, or the new
//     top after a push), min, max, fill count, full/empty flags and status.
//     Taken at a clock edge with rsp_valid high and rsp_stall low.
// Sequencing
//   Push: result registered at acceptance; a push every cycle while rsp_stall is low.
//   Pop: waits in ST_POP_WAIT for the stack RAM read (a pop on an empty stack
//     reads nothing and skips the wait). The new top entry comes from the RAM's
//     registered read port, so no new word is taken until it arrives.
//   One operation is in flight at a time; a new word is taken in the same
//   cycle as the previous result leaves the output register.
// Reset (synchronous, active high) empties the stack; RAM contents are left
//   as they are, since only entries below the count are ever used.
// When the receiver stalls, the result holds in the output register and
//   req_stall rises until it is taken. Overflow pushes are dropped (status
//   1), pops on an empty stack return zeros (status 2).

`include "min_max_stack_unit_assert.svh"

module min_max_stack_unit
   import mms_pkg::*;
#(
   parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  mms_req_type req_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output mms_rsp_type rsp_word
);

   localparam int CW      = $clog2(STACK_DEPTH + 1);
   localparam int AW      = $clog2(STACK_DEPTH);
   localparam int ENTRY_W = $bits(mms_entry_type);

   // Sequencer states
   localparam logic ST_IDLE     = 1'b0;
   localparam logic ST_POP_WAIT = 1'b1;

   logic                     state_ff, state_in;
   logic [CW-1:0]            count_ff, count_in;
   logic signed [DATA_W-1:0] top_val_ff, top_val_in;
   logic signed [DATA_W-1:0] top_min_ff, top_min_in;
   logic signed [DATA_W-1:0] top_max_ff, top_max_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   mms_rsp_type              rsp_word_ff, rsp_word_in;

   logic                     accept;
   logic                     rsp_load;
   logic                     stack_full;
   logic                     stack_empty;
   logic [CW-1:0]            count_m2;
   logic [CW+FILL_W-1:0]     fill_ext;
   logic signed [DATA_W-1:0] push_min;
   logic signed [DATA_W-1:0] push_max;

   logic                     wr_en;
   logic [AW-1:0]            wr_addr;
   mms_entry_type            wr_entry;
   logic                     rd_en;
   logic [AW-1:0]            rd_addr;
   logic [ENTRY_W-1:0]       rd_data;
   mms_entry_type            rd_entry;

   // Entries 0..count-1 live in RAM; the top one is also cached in flops
   mms_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_entry = mms_entry_type'(rd_data);

   // Take a word only when idle and the output register is free this cycle
   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   assign stack_full  = (count_ff == CW'(STACK_DEPTH));
   assign stack_empty = (count_ff == '0);
   assign count_m2    = count_ff - CW'(2);

   // New running min/max fold the pushed value into the cached top entry
   assign push_min = (stack_empty || (req_word.value < top_min_ff)) ?
                     req_word.value : top_min_ff;
   assign push_max = (stack_empty || (req_word.value > top_max_ff)) ?
                     req_word.value : top_max_ff;

   assign wr_addr = count_ff[AW-1:0];
   assign wr_entry = '{value: req_word.value, run_min: push_min, run_max: push_max};
   // Entry just below the popped one; wraps harmlessly when one entry is left
   assign rd_addr = count_m2[AW-1:0];

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      top_val_in  = top_val_ff;
      top_min_in  = top_min_ff;
      top_max_in  = top_max_ff;
      rsp_load    = 1'b0;
      rsp_word_in = rsp_word_ff;
      wr_en       = 1'b0;
      rd_en       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_word.cmd == CMD_PUSH) begin
                  rsp_load = 1'b1;
                  if (stack_full) begin
                     rsp_word_in.top_value = top_val_ff;
                     rsp_word_in.min_value = top_min_ff;
                     rsp_word_in.max_value = top_max_ff;
                     rsp_word_in.status    = STATUS_OVERFLOW;
                  end else begin
                     wr_en                 = 1'b1;
                     count_in              = count_ff + CW'(1);
                     top_val_in            = req_word.value;
                     top_min_in            = push_min;
                     top_max_in            = push_max;
                     rsp_word_in.top_value = req_word.value;
                     rsp_word_in.min_value = push_min;
                     rsp_word_in.max_value = push_max;
                     rsp_word_in.status    = STATUS_OK;
                  end
               end else if (stack_empty) begin
                  rsp_load              = 1'b1;
                  rsp_word_in.top_value = '0;
                  rsp_word_in.min_value = '0;
                  rsp_word_in.max_value = '0;
                  rsp_word_in.status    = STATUS_UNDERFLOW;
               end else begin
                  // Fetch the new top; result goes out once it arrives
                  rd_en    = 1'b1;
                  count_in = count_ff - CW'(1);
                  state_in = ST_POP_WAIT;
               end
            end
         end
         ST_POP_WAIT: begin
            // count_ff is already decremented; top_val_ff is the popped value
            rsp_load              = 1'b1;
            rsp_word_in.top_value = top_val_ff;
            rsp_word_in.status    = STATUS_OK;
            state_in              = ST_IDLE;
            if (stack_empty) begin
               rsp_word_in.min_value = '0;
               rsp_word_in.max_value = '0;
            end else begin
               top_val_in            = rd_entry.value;
               top_min_in            = rd_entry.run_min;
               top_max_in            = rd_entry.run_max;
               rsp_word_in.min_value = rd_entry.run_min;
               rsp_word_in.max_value = rd_entry.run_max;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Count and flags always describe the stack after the operation
      fill_ext               = {{FILL_W{1'b0}}, count_in};
      rsp_word_in.fill_count = fill_ext[FILL_W-1:0];
      rsp_word_in.is_full    = (count_in == CW'(STACK_DEPTH));
      rsp_word_in.is_empty   = (count_in == '0);
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_val_ff <= top_val_in;
      top_min_ff <= top_min_in;
      top_max_ff <= top_max_in;
      if (rsp_load) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // Checks
   `MMS_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(STACK_DEPTH),
      "stack count beyond depth")
   `MMS_ASSERT_NEXT(a_pop_waits, clock, reset,
      accept && (req_word.cmd == CMD_POP) && !stack_empty,
      (state_ff == ST_POP_WAIT) && !rsp_valid_ff,
      "pop did not wait for the RAM read")
   `MMS_ASSERT_IMPLY(a_empty_zero, clock, reset, rsp_valid_ff && rsp_word_ff.is_empty,
      (rsp_word_ff.min_value == '0) && (rsp_word_ff.max_value == '0),
      "min/max not zero on empty stack")
   `MMS_ASSERT_IMPLY(a_min_le_max, clock, reset,
      rsp_valid_ff && !rsp_word_ff.is_empty,
      rsp_word_ff.min_value <= rsp_word_ff.max_value,
      "min above max")

endmodule
